@@ hw/rtl/xfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xfp_pkg
// types, frame constants and reply tables of the bus frame parser
// ----------------------------------------------------------------------------
package xfp_pkg;

  // header bytes that select a reply
  localparam logic [7:0] HDR_IF_VERSION = 8'hF0;
  localparam logic [7:0] HDR_CS_REQ     = 8'h21;
  localparam logic [7:0] HDR_ACC_INFO   = 8'h42;
  localparam logic [7:0] HDR_ACC_OP     = 8'h52;

  // command station request codes, first payload byte
  localparam logic [7:0] CS_VERSION = 8'h21;
  localparam logic [7:0] CS_STATUS  = 8'h24;
  localparam logic [7:0] CS_STOP    = 8'h80;
  localparam logic [7:0] CS_RESUME  = 8'h81;

  typedef enum logic [3:0] {
    RPL_NONE,
    RPL_CKSUM_ERR,
    RPL_IF_VERSION,
    RPL_CS_VERSION,
    RPL_CS_STATUS,
    RPL_CS_STOP,
    RPL_CS_RESUME,
    RPL_ACC_INFO,
    RPL_ACC_OP,
    RPL_NOT_SUPP
  } reply_e;

  typedef struct packed {
    reply_e     code;
    logic [7:0] p0;
    logic [7:0] p1;
  } reply_desc_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [6:0] board;
    logic [2:0] output_number;
    logic       direction;
    logic       activate;
    logic       last;
  } result_t;

  // number of results of a reply
  function automatic logic [2:0] reply_len(reply_e code);
    logic [2:0] n;
    case (code)
      RPL_CKSUM_ERR:  n = 3'd3;
      RPL_IF_VERSION: n = 3'd4;
      RPL_CS_VERSION: n = 3'd5;
      RPL_CS_STATUS:  n = 3'd4;
      RPL_CS_STOP:    n = 3'd3;
      RPL_CS_RESUME:  n = 3'd3;
      RPL_ACC_INFO:   n = 3'd4;
      RPL_ACC_OP:     n = 3'd5;
      RPL_NOT_SUPP:   n = 3'd3;
      default:        n = 3'd0;
    endcase
    return n;
  endfunction

  // byte to transmit at position idx of a reply
  function automatic logic [7:0] reply_byte(reply_e code, logic [2:0] idx,
                                            logic [7:0] p0, logic [7:0] p1);
    logic [7:0] b;
    logic [7:0] d1;
    d1 = p1[0] ? 8'h10 : 8'h00;
    b  = 8'h00;
    case (code)
      RPL_CKSUM_ERR: begin
        case (idx)
          3'd0:    b = 8'h61;
          3'd1:    b = 8'h80;
          default: b = 8'hE1;
        endcase
      end
      RPL_IF_VERSION: begin
        case (idx)
          3'd0:    b = 8'h02;
          3'd1:    b = 8'h30;
          3'd2:    b = 8'h01;
          default: b = 8'h33;
        endcase
      end
      RPL_CS_VERSION: begin
        case (idx)
          3'd0:    b = 8'h63;
          3'd1:    b = 8'h21;
          3'd2:    b = 8'h30;
          3'd3:    b = 8'h00;
          default: b = 8'h72;
        endcase
      end
      RPL_CS_STATUS: begin
        case (idx)
          3'd0:    b = 8'h62;
          3'd1:    b = 8'h22;
          3'd2:    b = 8'h00;
          default: b = 8'h40;
        endcase
      end
      RPL_CS_STOP: begin
        case (idx)
          3'd0:    b = 8'h61;
          3'd1:    b = 8'h00;
          default: b = 8'h61;
        endcase
      end
      RPL_CS_RESUME: begin
        case (idx)
          3'd0:    b = 8'h61;
          3'd1:    b = 8'h01;
          default: b = 8'h60;
        endcase
      end
      RPL_ACC_INFO: begin
        case (idx)
          3'd0:    b = 8'h42;
          3'd1:    b = p0;
          3'd2:    b = d1;
          default: b = 8'h42 ^ p0 ^ d1;
        endcase
      end
      RPL_ACC_OP: begin
        // position zero is the notification
        case (idx)
          3'd0:    b = 8'h00;
          3'd1:    b = 8'h42;
          3'd2:    b = 8'hFF;
          3'd3:    b = 8'h40;
          default: b = 8'hFD;
        endcase
      end
      RPL_NOT_SUPP: begin
        case (idx)
          3'd0:    b = 8'h61;
          3'd1:    b = 8'h82;
          default: b = 8'hE3;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // full result at position idx of a reply
  function automatic result_t reply_result(reply_e code, logic [2:0] idx,
                                           logic [7:0] p0, logic [7:0] p1);
    result_t r;
    logic    notify;
    notify          = (code == RPL_ACC_OP) && (idx == 3'd0);
    r               = '0;
    r.kind          = notify;
    r.tx_byte       = reply_byte(code, idx, p0, p1);
    r.board         = notify ? p0[7:1] : 7'd0;
    r.output_number = notify ? {p0[0], p1[2], p1[1]} : 3'd0;
    r.direction     = notify & p1[0];
    r.activate      = notify & p1[3];
    r.last          = (idx == reply_len(code) - 3'd1);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/xfp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xfp_if
// valid/ready channels for received bytes and for results
// ----------------------------------------------------------------------------
interface xfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xfp_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [6:0] board;
  logic [2:0] output_number;
  logic       direction;
  logic       activate;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output board,
                  output output_number, output direction, output activate,
                  output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input board,
                  input output_number, input direction, input activate,
                  input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/xbus_frame_parser_responder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xbus_frame_parser_responder
// parses received bus frames, checks the checksum and sends replies
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                        transaction
//  rx_i     in   rx_byte                                        valid & ready
//  res_o    out  kind tx_byte board output_number direction     valid & ready
//                activate last
//
// header and payload bytes never wait for the emitter and cause no result
// a checksum byte loads a reply of three to five results, one per cycle while
// res_o is ready, or none for an unknown command station request;
// the result emitter sets the rate for checksum bytes
// rx_i stays ready while a reply drains unless a second reply is waiting
// in the input register; a stall on res_o holds the current result
// reset is asynchronous and active low; the parser then waits for a header
// ----------------------------------------------------------------------------
module xbus_frame_parser_responder (
  input  wire        clk_i,
  input  wire        rst_ni,
  xfp_rx_if.sink     rx_i,
  xfp_res_if.source  res_o
);

  // descriptor of a reply handed from the parser to the emitter
  xfp_pkg::reply_desc_t desc;
  logic                 desc_valid;
  logic                 load_ok;

  // input register, frame state and reply decode
  xfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .load_ok_i    (load_ok),
    .desc_valid_o (desc_valid),
    .desc_o       (desc)
  );

  // result sequencing toward the bus transmitter
  xfp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .load_ok_o    (load_ok),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/xfp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xfp_parser
// input register, frame state and reply decode
// ----------------------------------------------------------------------------
module xfp_parser (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  xfp_rx_if.sink              rx_i,
  input  wire                 load_ok_i,
  output logic                desc_valid_o,
  output xfp_pkg::reply_desc_t desc_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       wait_hdr_q, wait_hdr_d;
  logic [3:0] remain_q, remain_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] csum_q, csum_d;
  logic [7:0] p0_q, p0_d;
  logic [7:0] p1_q, p1_d;
  logic [3:0] pidx_q, pidx_d;

  xfp_pkg::reply_e code;
  logic            is_cksum;
  logic            consume;

  always_comb begin
    is_cksum = !wait_hdr_q && (remain_q == 4'd0);
    code     = xfp_pkg::RPL_NONE;
    if (is_cksum) begin
      if (in_byte_q != csum_q) begin
        code = xfp_pkg::RPL_CKSUM_ERR;
      end else begin
        case (hdr_q)
          xfp_pkg::HDR_IF_VERSION: code = xfp_pkg::RPL_IF_VERSION;
          xfp_pkg::HDR_CS_REQ: begin
            case (p0_q)
              xfp_pkg::CS_VERSION: code = xfp_pkg::RPL_CS_VERSION;
              xfp_pkg::CS_STATUS:  code = xfp_pkg::RPL_CS_STATUS;
              xfp_pkg::CS_STOP:    code = xfp_pkg::RPL_CS_STOP;
              xfp_pkg::CS_RESUME:  code = xfp_pkg::RPL_CS_RESUME;
              default:             code = xfp_pkg::RPL_NONE;
            endcase
          end
          xfp_pkg::HDR_ACC_INFO: code = xfp_pkg::RPL_ACC_INFO;
          xfp_pkg::HDR_ACC_OP:   code = xfp_pkg::RPL_ACC_OP;
          default:               code = xfp_pkg::RPL_NOT_SUPP;
        endcase
      end
    end
  end

  // a byte with a reply waits until the emitter can take it
  assign consume      = in_valid_q && ((code == xfp_pkg::RPL_NONE) || load_ok_i);
  assign rx_i.ready   = !in_valid_q || consume;
  assign desc_valid_o = in_valid_q && (code != xfp_pkg::RPL_NONE);
  assign desc_o.code  = code;
  assign desc_o.p0    = p0_q;
  assign desc_o.p1    = p1_q;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    wait_hdr_d = wait_hdr_q;
    remain_d   = remain_q;
    hdr_d      = hdr_q;
    csum_d     = csum_q;
    p0_d       = p0_q;
    p1_d       = p1_q;
    pidx_d     = pidx_q;
    if (consume) begin
      in_valid_d = 1'b0;
      if (wait_hdr_q) begin
        remain_d   = in_byte_q[3:0];
        hdr_d      = in_byte_q;
        csum_d     = in_byte_q;
        pidx_d     = 4'd0;
        wait_hdr_d = 1'b0;
      end else if (is_cksum) begin
        wait_hdr_d = 1'b1;
      end else begin
        if (pidx_q == 4'd0) begin
          p0_d = in_byte_q;
        end else if (pidx_q == 4'd1) begin
          p1_d = in_byte_q;
        end
        if (pidx_q != 4'd15) begin
          pidx_d = pidx_q + 4'd1;
        end
        csum_d   = csum_q ^ in_byte_q;
        remain_d = remain_q - 4'd1;
      end
    end
    if (rx_i.valid && rx_i.ready) begin
      in_valid_d = 1'b1;
      in_byte_d  = rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      wait_hdr_q <= 1'b1;
      remain_q   <= 4'd0;
      hdr_q      <= 8'd0;
      csum_q     <= 8'd0;
      p0_q       <= 8'd0;
      p1_q       <= 8'd0;
      pidx_q     <= 4'd0;
    end else begin
      in_valid_q <= in_valid_d;
      wait_hdr_q <= wait_hdr_d;
      remain_q   <= remain_d;
      hdr_q      <= hdr_d;
      csum_q     <= csum_d;
      p0_q       <= p0_d;
      p1_q       <= p1_d;
      pidx_q     <= pidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/xfp_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xfp_emitter
// holds one reply and sends its results one per cycle while res_o is ready
// ----------------------------------------------------------------------------
module xfp_emitter (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  desc_valid_i,
  input  wire xfp_pkg::reply_desc_t desc_i,
  output logic                 load_ok_o,
  xfp_res_if.source            res_o
);

  logic                 busy_q, busy_d;
  logic [2:0]           idx_q, idx_d;
  xfp_pkg::reply_desc_t desc_q, desc_d;
  xfp_pkg::result_t     res;
  logic                 fire;
  logic                 load;

  assign res  = xfp_pkg::reply_result(desc_q.code, idx_q, desc_q.p0, desc_q.p1);
  assign fire = busy_q && res_o.ready;

  assign load_ok_o = !busy_q || (fire && res.last);
  assign load      = desc_valid_i && load_ok_o;

  assign res_o.valid         = busy_q;
  assign res_o.kind          = res.kind;
  assign res_o.tx_byte       = res.tx_byte;
  assign res_o.board         = res.board;
  assign res_o.output_number = res.output_number;
  assign res_o.direction     = res.direction;
  assign res_o.activate      = res.activate;
  assign res_o.last          = res.last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    desc_d = desc_q;
    if (fire) begin
      if (res.last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = 3'd0;
      desc_d = desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  // position never runs past the reply length
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < xfp_pkg::reply_len(desc_q.code)))
    else $error("emitter position beyond reply length");

  // a held reply always has results
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (desc_q.code != xfp_pkg::RPL_NONE))
    else $error("emitter holds an empty reply");

  // a new reply only replaces one whose final result goes out now
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && busy_q) |-> (fire && res.last))
    else $error("reply overwritten before completion");

  // after the final result with nothing loaded the emitter goes idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.last && !desc_valid_i) |=> !busy_q)
    else $error("emitter stays busy after final result");

endmodule
`default_nettype wire
